>>> rtl/p2g_pkg.sv
// Shared constants, types and functions of the pixel to gimbal angle core.
package p2g_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int FRAME_WIDTH_DEF = 320;
  localparam int FRAME_HEIGHT_DEF = 240;
  localparam int NUM_W = 32;
  localparam int XY_W = 36;
  localparam int Z_W = 24;
  localparam int ADDR_W = 4;
  localparam logic [31:0] DEG_SCALE_Q30 = 32'd1073742731;

  localparam logic [ADDR_W-1:0] REG_FOCAL_X = 4'h0;
  localparam logic [ADDR_W-1:0] REG_FOCAL_Y = 4'h4;
  localparam logic [ADDR_W-1:0] REG_CENTER_X = 4'h8;
  localparam logic [ADDR_W-1:0] REG_CENTER_Y = 4'hC;

  localparam logic signed [Z_W-1:0] Z_90 = 24'sd5898240;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   fixed;
  } cordic_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0: v = 24'sd2949120;  1: v = 24'sd1740967;  2: v = 24'sd919879;
      3: v = 24'sd466945;   4: v = 24'sd234379;   5: v = 24'sd117304;
      6: v = 24'sd58666;    7: v = 24'sd29335;    8: v = 24'sd14668;
      9: v = 24'sd7334;     10: v = 24'sd3667;    11: v = 24'sd1833;
      12: v = 24'sd917;     13: v = 24'sd458;     14: v = 24'sd229;
      15: v = 24'sd115;     16: v = 24'sd57;      17: v = 24'sd29;
      18: v = 24'sd14;      19: v = 24'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/pixel_to_gimbal_angle_core.sv
// Top level of the pixel to gimbal angle core.
//   channel | dir | fields
//   in_     | in  | tdata: norm_x[15:0], norm_y[31:16]
//   out_    | out | tdata: pan_deg[15:0], tilt_deg[30:16], zero[31]
//   cfg_    | in  | APB registers focal_x, focal_y, center_x, center_y
// One transfer per cycle while the output is not stalled; the pipeline registers are offset,
// 20 CORDIC stages, multiply and clamp. Reset restores the register defaults and empties the pipe.
// A stall on the output freezes the whole pipeline; no item is lost.
module pixel_to_gimbal_angle_core #(
  parameter int FRAME_WIDTH = p2g_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = p2g_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // norm_x, norm_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pan_deg, tilt_deg
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [p2g_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import p2g_pkg::*;

  localparam int LAT = CORDIC_STEPS + 3;

  logic [15:0] focal_x_r, focal_y_r;
  logic [12:0] center_x_r;
  logic [11:0] center_y_r;
  logic [LAT-1:0] vld_r;
  logic en, wr;
  logic signed [15:0] pan;
  logic signed [14:0] tilt;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r <= 16'd4096;
      focal_y_r <= 16'd4096;
      center_x_r <= 13'd2560;
      center_y_r <= 12'd1920;
    end else if (wr) begin
      case (cfg_paddr)
        REG_FOCAL_X: focal_x_r <= cfg_pwdata[15:0];
        REG_FOCAL_Y: focal_y_r <= cfg_pwdata[15:0];
        REG_CENTER_X: center_x_r <= cfg_pwdata[12:0];
        REG_CENTER_Y: center_y_r <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_FOCAL_X: cfg_prdata = {16'd0, focal_x_r};
      REG_FOCAL_Y: cfg_prdata = {16'd0, focal_y_r};
      REG_CENTER_X: cfg_prdata = {19'd0, center_x_r};
      REG_CENTER_Y: cfg_prdata = {20'd0, center_y_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  p2g_axis #(.FRAME(FRAME_WIDTH), .OUT_W(16), .LO(-23040), .HI(23040)) u_pan (
    .clk(clk), .en(en), .norm(in_tdata[15:0]), .focal(focal_x_r),
    .center(center_x_r), .angle(pan)
  );

  p2g_axis #(.FRAME(FRAME_HEIGHT), .OUT_W(15), .LO(-7680), .HI(15360)) u_tilt (
    .clk(clk), .en(en), .norm(in_tdata[31:16]), .focal(focal_y_r),
    .center({1'b0, center_y_r}), .angle(tilt)
  );

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata = {1'b0, tilt, pan};

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(pan) <= 23040 && $signed(pan) >= -23040))
    else $error("pan out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(tilt) <= 15360 && $signed(tilt) >= -7680))
    else $error("tilt out of range");
endmodule

>>> rtl/p2g_cordic_stage.sv
// One registered vectoring CORDIC iteration.
module p2g_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             en,
  input  p2g_pkg::cordic_t d_in,
  output p2g_pkg::cordic_t d_out
);
  import p2g_pkg::*;

  cordic_t q_r, q_nxt;
  logic signed [XY_W-1:0] xs, ys;

  always_comb begin
    xs = d_in.x >>> STEP;
    ys = d_in.y >>> STEP;
    q_nxt = d_in;
    if (!d_in.fixed) begin
      if (d_in.y > 0) begin
        q_nxt.x = d_in.x + ys;
        q_nxt.y = d_in.y - xs;
        q_nxt.z = d_in.z + atan_entry(STEP);
      end else begin
        q_nxt.x = d_in.x - ys;
        q_nxt.y = d_in.y + xs;
        q_nxt.z = d_in.z - atan_entry(STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;
endmodule

>>> rtl/p2g_axis.sv
// Angle pipeline of one axis: offset, CORDIC stages, degree scaling and clamp.
module p2g_axis #(
  parameter int FRAME = p2g_pkg::FRAME_WIDTH_DEF,
  parameter int OUT_W = 16,
  parameter int LO = -23040,
  parameter int HI = 23040
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [15:0]             norm,
  input  logic [15:0]             focal,
  input  logic [12:0]             center,
  output logic signed [OUT_W-1:0] angle
);
  import p2g_pkg::*;

  cordic_t s0_r, s0_nxt;
  cordic_t chain [CORDIC_STEPS+1];
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [OUT_W-1:0] angle_r, angle_nxt;
  logic signed [NUM_W-1:0] num;
  logic signed [63:0] q8;

  always_comb begin
    num = NUM_W'($signed({1'b0, NUM_W'(norm) * NUM_W'(FRAME)}) -
                 $signed({1'b0, center, 12'd0}));
    s0_nxt.x = $signed({8'd0, focal, 12'd0});
    s0_nxt.y = XY_W'(num);
    s0_nxt.z = '0;
    s0_nxt.fixed = 1'b0;
    if (num == 0) begin
      s0_nxt.fixed = 1'b1;
    end else if (focal == 16'd0) begin
      s0_nxt.fixed = 1'b1;
      s0_nxt.z = (num > 0) ? Z_90 : -Z_90;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= s0_nxt;
    end
  end

  assign chain[0] = s0_r;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    p2g_cordic_stage #(.STEP(g)) u_stage (
      .clk(clk), .en(en), .d_in(chain[g]), .d_out(chain[g+1])
    );
  end

  assign prod_nxt = 64'(chain[CORDIC_STEPS].z) * $signed({32'd0, DEG_SCALE_Q30});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    q8 = (prod_r + (64'sd1 <<< 37)) >>> 38;
    if (q8 > 64'(HI)) begin
      angle_nxt = OUT_W'(HI);
    end else if (q8 < 64'(LO)) begin
      angle_nxt = OUT_W'(LO);
    end else begin
      angle_nxt = OUT_W'(q8);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle = angle_r;
endmodule

>>> tb/pixel_to_gimbal_angle_core_tb.sv
// Self-checking testbench of the pixel to gimbal angle core: directed table, random traffic.
`timescale 1ns / 1ps
module pixel_to_gimbal_angle_core_tb;
  import p2g_pkg::*;

  localparam int LATENCY = 23;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [31:0] in_tdata;  // norm_x[15:0], norm_y[31:16]
  logic out_tvalid, out_tready;
  logic [31:0] out_tdata;  // pan_deg[15:0], tilt_deg[30:16], zero[31]
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  pixel_to_gimbal_angle_core DUT (.*);

  typedef struct packed {
    logic signed [14:0] tilt;
    logic signed [15:0] pan;
  } angles_t;

  typedef struct {
    logic [15:0] nx;
    logic [15:0] ny;
    logic        known;
    angles_t     ang;
  } stim_row_t;

  logic [15:0] focal_x_q, focal_y_q;
  logic [12:0] center_x_q;
  logic [11:0] center_y_q;
  angles_t angle_fifo[$];
  int n_mismatch, n_results;
  int send_idle_pct, recv_stall_pct, hold_cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout waiting for results.");
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q16(longint num, longint den);
    longint x, y, z, xs, ys;
    longint tab[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    x = den; y = num; z = 0;
    if (num == 0) return 0;
    if (den == 0) return num > 0 ? 90 * 65536 : -90 * 65536;
    for (int i = 0; i < 20; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += tab[i];
      end else begin
        x = x - ys; y = y + xs; z -= tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint axis_q8(longint norm, longint frame, longint center,
                                     longint focal, longint lo, longint hi);
    longint z, q;
    z = atan_q16(norm * frame - center * 4096, focal * 4096);
    q = floor_shift(z * 64'sd1073742731 + (64'sd1 <<< 37), 38);
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q;
  endfunction

  function automatic angles_t gimbal_angles(logic [15:0] nx, logic [15:0] ny);
    angles_t a;
    a.pan = 16'(axis_q8(nx, 320, center_x_q, focal_x_q, -23040, 23040));
    a.tilt = 15'(axis_q8(ny, 240, center_y_q, focal_y_q, -7680, 15360));
    return a;
  endfunction

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (addr)
      REG_FOCAL_X: focal_x_q = value[15:0];
      REG_FOCAL_Y: focal_y_q = value[15:0];
      REG_CENTER_X: center_x_q = value[12:0];
      REG_CENTER_Y: center_y_q = value[11:0];
      default: ;
    endcase
  endtask

  task automatic set_optics(int fx, int fy, int cx, int cy);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
  endtask

  task automatic send_target(logic [15:0] nx, logic [15:0] ny, bit known, angles_t ang);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {ny, nx};
    do @(posedge clk); while (!in_tready);
    angle_fifo.push_back(known ? ang : gimbal_angles(nx, ny));
    @(negedge clk);
  endtask

  task automatic drain();
    int guard = 0;
    in_tvalid <= 0;
    while (angle_fifo.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    angles_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[30:0];
      n_results++;
      if (angle_fifo.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("Unexpected transfer: pan %0d tilt %0d", got.pan, got.tilt);
      end else begin
        want = angle_fifo.pop_front();
        if (got.pan !== want.pan || got.tilt !== want.tilt || out_tdata[31] !== 1'b0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("Mismatch: pan %0d/%0d tilt %0d/%0d (expected/actual)",
                     want.pan, got.pan, want.tilt, got.tilt);
        end
      end
    end
  end

  stim_row_t directed[] = '{
    '{16'h8000, 16'h8000, 1'b1, '{tilt: 15'sd0, pan: 16'sd0}},
    '{16'h0000, 16'h0000, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{16'h0000, 16'hFFFF, 1'b0, '0},
    '{16'hFFFF, 16'h0000, 1'b0, '0},
    '{16'h5555, 16'hAAAA, 1'b0, '0},
    '{16'hAAAA, 16'h5555, 1'b0, '0},
    '{16'h8001, 16'h7FFF, 1'b0, '0}
  };

  initial begin
    int phase;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    focal_x_q = 4096; focal_y_q = 4096; center_x_q = 2560; center_y_q = 1920;
    n_mismatch = 0; n_results = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (directed[i]) send_target(directed[i].nx, directed[i].ny, directed[i].known,
                                      directed[i].ang);
    drain();
    // Zero focal lengths give the clamped extremes; a zero offset still gives zero.
    set_optics(0, 0, 0, 3840);
    send_target(16'hFFFF, 16'h0000, 1'b1, '{tilt: -15'sd7680, pan: 16'sd23040});
    send_target(16'h0000, 16'hFFFF, 1'b0, '0);
    send_target(16'h0000, 16'h0000, 1'b1, '{tilt: -15'sd7680, pan: 16'sd0});
    drain();
    set_optics(65535, 65535, 8191, 4095);
    for (int i = 0; i < 6; i++) send_target(16'($urandom), 16'($urandom), 1'b0, '0);
    drain();
    write_reg(REG_FOCAL_X, 16); write_reg(REG_FOCAL_Y, 16);
    send_target(16'h0000, 16'hFFFF, 1'b0, '0);
    send_target(16'hFFFF, 16'h0000, 1'b0, '0);
    drain();

    // Long receiver hold-off while targets keep coming.
    set_optics(4096, 4096, 2560, 1920);
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) send_target(16'($urandom), 16'($urandom), 1'b0, '0);
    drain();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 78; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 78; end
        3: begin send_idle_pct = 25; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      set_optics($urandom_range(16, 65535) >> $urandom_range(0, 10) | 16,
                 $urandom_range(16, 65535) >> $urandom_range(0, 10) | 16,
                 $urandom_range(0, 5120), $urandom_range(0, 3840));
      for (int i = 0; i < 215; i++) begin
        if ($urandom_range(3) == 0)
          send_target(16'h8000 + 16'($urandom_range(0, 255)) - 16'd128,
                      16'h8000 + 16'($urandom_range(0, 255)) - 16'd128, 1'b0, '0);
        else
          send_target(16'($urandom), 16'($urandom), 1'b0, '0);
      end
      drain();
    end

    $display("Covered %0d results over directed extremes, zero focal lengths and five",
             n_results);
    $display("random optics settings with sender gaps and receiver stalls.");
    if (n_mismatch == 0 && angle_fifo.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing.", n_mismatch, angle_fifo.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
